FILE: rtl/tcid_pkg.sv
// ----------------------------------------------------------------------------
// tcid_pkg
// Shared widths, register indexes and threshold tables of the
// temperature-compensated infrared crack detector.
// ----------------------------------------------------------------------------
package tcid_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int ZONES       = 3;
    localparam int CHANNELS    = 8;
    localparam int ZONE_BITS   = 2;
    localparam int CH_BITS     = 3;
    localparam int TEMP_BITS   = 12;
    localparam int MASK_BITS   = 8;
    localparam int INDEX_BITS  = 2;
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int SPAN_BITS   = 5;
    localparam int SLOPE_BITS  = 12;
    localparam int CMP_BITS    = 17;

    // reciprocal of 3 in 0.17 fixed point, exact for sums below 2^16
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_BITS  = 16;
    localparam logic [RECIP_BITS-1:0] RECIP3 = 16'hAAAB;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    // zone codes
    localparam logic [ZONE_BITS-1:0] ZONE_LEFT   = 2'd0;
    localparam logic [ZONE_BITS-1:0] ZONE_CENTER = 2'd1;
    localparam logic [ZONE_BITS-1:0] ZONE_RIGHT  = 2'd2;
    localparam logic [ZONE_BITS-1:0] ZONE_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [INDEX_BITS-1:0] REG_LEFT_MASK   = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_CENTER_MASK = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_RIGHT_MASK  = 2'd2;

    localparam logic [MASK_BITS-1:0] LEFT_MASK_RST   = 8'd3;
    localparam logic [MASK_BITS-1:0] CENTER_MASK_RST = 8'd243;
    localparam logic [MASK_BITS-1:0] RIGHT_MASK_RST  = 8'd3;

    // per-zone tracking state
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] min_value;
        logic [CH_BITS-1:0]     min_channel;
        logic                   crack;
    } zone_state_t;

    localparam zone_state_t ZONE_STATE_RST = '{
        min_value:   SAMPLE_MAX,
        min_channel: '0,
        crack:       1'b0
    };

    // mild anchor temperature in tenths of a degree
    function automatic logic signed [TEMP_BITS-1:0] anchor_mild(
        input logic [ZONE_BITS-1:0] z);
        logic signed [TEMP_BITS-1:0] t;
        case (z)
            ZONE_CENTER: t = 12'sd314;
            default:     t = 12'sd316;
        endcase
        return t;
    endfunction

    // hot anchor temperature in tenths of a degree
    function automatic logic signed [TEMP_BITS-1:0] anchor_hot(
        input logic [ZONE_BITS-1:0] z);
        return 12'sd330;
    endfunction

    // hot minus mild anchor
    function automatic logic [SPAN_BITS-1:0] anchor_span(
        input logic [ZONE_BITS-1:0] z);
        logic [SPAN_BITS-1:0] s;
        case (z)
            ZONE_CENTER: s = 5'd16;
            default:     s = 5'd14;
        endcase
        return s;
    endfunction

    // mild level times the zone span; right zone shares the left tables
    function automatic logic [CMP_BITS-1:0] level_base(
        input logic [ZONE_BITS-1:0] z,
        input logic [CH_BITS-1:0]   ch);
        logic [CMP_BITS-1:0] v;
        if (z == ZONE_CENTER)
        begin
            case (ch)
                3'd3:    v = 17'd6016;
                3'd4:    v = 17'd2528;
                3'd5:    v = 17'd2800;
                3'd6:    v = 17'd4080;
                3'd7:    v = 17'd3536;
                default: v = 17'd0;
            endcase
        end
        else
        begin
            case (ch)
                3'd0:    v = 17'd5180;
                3'd1:    v = 17'd7714;
                3'd2:    v = 17'd7910;
                3'd3:    v = 17'd9058;
                default: v = 17'd0;
            endcase
        end
        return v;
    endfunction

    // hot level minus mild level
    function automatic logic [SLOPE_BITS-1:0] level_slope(
        input logic [ZONE_BITS-1:0] z,
        input logic [CH_BITS-1:0]   ch);
        logic [SLOPE_BITS-1:0] v;
        if (z == ZONE_CENTER)
        begin
            case (ch)
                3'd3:    v = 12'd507;
                3'd4:    v = 12'd474;
                3'd5:    v = 12'd604;
                3'd6:    v = 12'd851;
                3'd7:    v = 12'd923;
                default: v = 12'd0;
            endcase
        end
        else
        begin
            case (ch)
                3'd0:    v = 12'd1110;
                3'd1:    v = 12'd1653;
                3'd2:    v = 12'd1695;
                3'd3:    v = 12'd1941;
                default: v = 12'd0;
            endcase
        end
        return v;
    endfunction

endpackage

FILE: rtl/temp_compensated_ir_crack_detector.sv
// ----------------------------------------------------------------------------
// temp_compensated_ir_crack_detector
// Averages three readings of one channel, compares the average against a
// temperature-interpolated threshold and tracks per-zone minimum and crack.
// ----------------------------------------------------------------------------
//
//  channel   signals                       direction  beat when
//  item      item_valid / item_stall       in         valid high, stall low
//  result    result_valid / result_stall   out        valid high, stall low
//  config    cfg_write / cfg_index / data  in         cfg_write high
//
//  one item per cycle sustained while the result is not stalled; items
//  pass the input register, then the average/threshold/zone update into
//  the result register; zone state updates on the same edge as the result.
//  reset sets the masks to their defaults and clears all zone state.
//  a stalled result holds the pipeline; one more item is taken into the
//  input register before item_stall rises.
//
module temp_compensated_ir_crack_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    // item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                scan_start,
    input  logic [tcid_pkg::ZONE_BITS-1:0]      zone,
    input  logic [tcid_pkg::CH_BITS-1:0]        channel,
    input  logic [tcid_pkg::SAMPLE_BITS-1:0]    reading_a,
    input  logic [tcid_pkg::SAMPLE_BITS-1:0]    reading_b,
    input  logic [tcid_pkg::SAMPLE_BITS-1:0]    reading_c,
    input  logic signed [tcid_pkg::TEMP_BITS-1:0] temp_tenths,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [tcid_pkg::ZONE_BITS-1:0]      out_zone,
    output logic [tcid_pkg::CH_BITS-1:0]        out_channel,
    output logic [tcid_pkg::SAMPLE_BITS-1:0]    average,
    output logic                                channel_active,
    output logic                                below_threshold,
    output logic [tcid_pkg::SAMPLE_BITS-1:0]    zone_minimum,
    output logic [tcid_pkg::CH_BITS-1:0]        zone_minimum_channel,
    output logic                                zone_crack,
    // configuration
    input  logic                                cfg_write,
    input  logic [tcid_pkg::INDEX_BITS-1:0]     cfg_index,
    input  logic [tcid_pkg::MASK_BITS-1:0]      cfg_data
);
    import tcid_pkg::*;

    // input stage
    logic                          in_valid_reg;
    logic                          scan_reg;
    logic [ZONE_BITS-1:0]          zone_reg;
    logic [CH_BITS-1:0]            channel_reg;
    logic [SAMPLE_BITS-1:0]        ra_reg;
    logic [SAMPLE_BITS-1:0]        rb_reg;
    logic [SAMPLE_BITS-1:0]        rc_reg;
    logic signed [TEMP_BITS-1:0]   temp_reg;

    // result stage
    logic                          out_valid_reg;
    logic [ZONE_BITS-1:0]          out_zone_reg;
    logic [CH_BITS-1:0]            out_channel_reg;
    logic [SAMPLE_BITS-1:0]        average_reg;
    logic                          active_reg;
    logic                          below_reg;
    logic [SAMPLE_BITS-1:0]        zmin_reg;
    logic [CH_BITS-1:0]            zmin_ch_reg;
    logic                          zcrack_reg;

    // configuration and zone state
    logic [MASK_BITS-1:0]          left_mask_reg;
    logic [MASK_BITS-1:0]          center_mask_reg;
    logic [MASK_BITS-1:0]          right_mask_reg;
    zone_state_t                   zone_state_reg  [ZONES];
    zone_state_t                   zone_state_next [ZONES];

    // datapath signals
    logic                          advance;
    logic [SUM_BITS-1:0]           sum;
    logic [PROD_BITS-1:0]          recip_prod;
    logic [SAMPLE_BITS-1:0]        avg;
    logic                          zone_ok;
    logic [MASK_BITS-1:0]          mask_sel;
    logic                          active;
    logic signed [TEMP_BITS-1:0]   t_mild;
    logic signed [TEMP_BITS-1:0]   t_hot;
    logic signed [TEMP_BITS-1:0]   t_clamp;
    logic signed [TEMP_BITS-1:0]   t_delta;
    logic [SPAN_BITS-1:0]          dt;
    logic [CMP_BITS-1:0]           lhs;
    logic [CMP_BITS-1:0]           rhs;
    logic                          below;
    zone_state_t                   cur_state;
    zone_state_t                   upd_state;

    // handshake: stall only when both stages hold and the result is stalled
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && out_valid_reg && result_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!item_stall)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            scan_reg    <= scan_start;
            zone_reg    <= zone;
            channel_reg <= channel;
            ra_reg      <= reading_a;
            rb_reg      <= reading_b;
            rc_reg      <= reading_c;
            temp_reg    <= temp_tenths;
        end
    end

    // average: sum times reciprocal of three
    always_comb
    begin
        sum        = SUM_BITS'(ra_reg) + SUM_BITS'(rb_reg) + SUM_BITS'(rc_reg);
        recip_prod = PROD_BITS'(sum) * PROD_BITS'(RECIP3);
        avg        = recip_prod[RECIP_SHIFT +: SAMPLE_BITS];
    end

    // zone mask and channel enable
    always_comb
    begin
        case (zone_reg)
            ZONE_LEFT:   mask_sel = left_mask_reg;
            ZONE_CENTER: mask_sel = center_mask_reg;
            ZONE_RIGHT:  mask_sel = right_mask_reg;
            default:     mask_sel = '0;
        endcase
        zone_ok = (32'(zone_reg) < ZONES);
        active  = zone_ok && (32'(channel_reg) < CHANNELS) && mask_sel[channel_reg];
    end

    // threshold test: avg * span < mild * span + slope * (t - tm)
    always_comb
    begin
        t_mild = anchor_mild(zone_reg);
        t_hot  = anchor_hot(zone_reg);
        if (temp_reg < t_mild)
            t_clamp = t_mild;
        else if (temp_reg > t_hot)
            t_clamp = t_hot;
        else
            t_clamp = temp_reg;
        t_delta = t_clamp - t_mild;
        dt      = t_delta[SPAN_BITS-1:0];
        lhs     = CMP_BITS'(avg) * CMP_BITS'(anchor_span(zone_reg));
        rhs     = level_base(zone_reg, channel_reg)
                + CMP_BITS'(level_slope(zone_reg, channel_reg)) * CMP_BITS'(dt);
        below   = active && (lhs < rhs);
    end

    // zone state update, scan start clears every zone first
    always_comb
    begin
        cur_state = ZONE_STATE_RST;
        for (int z = 0; z < ZONES; z++)
        begin
            zone_state_next[z] = scan_reg ? ZONE_STATE_RST : zone_state_reg[z];
            if (zone_ok && (32'(zone_reg) == z))
                cur_state = zone_state_next[z];
        end
        upd_state = cur_state;
        if (active)
        begin
            if (avg < cur_state.min_value)
            begin
                upd_state.min_value   = avg;
                upd_state.min_channel = channel_reg;
            end
            if (below)
                upd_state.crack = 1'b1;
        end
        for (int z = 0; z < ZONES; z++)
        begin
            if (zone_ok && (32'(zone_reg) == z))
                zone_state_next[z] = upd_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int z = 0; z < ZONES; z++)
                zone_state_reg[z] <= ZONE_STATE_RST;
        end
        else if (advance)
        begin
            for (int z = 0; z < ZONES; z++)
                zone_state_reg[z] <= zone_state_next[z];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_mask_reg   <= LEFT_MASK_RST;
            center_mask_reg <= CENTER_MASK_RST;
            right_mask_reg  <= RIGHT_MASK_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LEFT_MASK:   left_mask_reg   <= cfg_data;
                REG_CENTER_MASK: center_mask_reg <= cfg_data;
                REG_RIGHT_MASK:  right_mask_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_zone_reg    <= zone_reg;
            out_channel_reg <= channel_reg;
            average_reg     <= avg;
            active_reg      <= active;
            below_reg       <= below;
            zmin_reg        <= upd_state.min_value;
            zmin_ch_reg     <= upd_state.min_channel;
            zcrack_reg      <= upd_state.crack;
        end
    end

    // outputs
    assign result_valid         = out_valid_reg;
    assign out_zone             = out_zone_reg;
    assign out_channel          = out_channel_reg;
    assign average              = average_reg;
    assign channel_active       = active_reg;
    assign below_threshold      = below_reg;
    assign zone_minimum         = zmin_reg;
    assign zone_minimum_channel = zmin_ch_reg;
    assign zone_crack           = zcrack_reg;

endmodule

FILE: rtl/tcid_checker.sv
// ----------------------------------------------------------------------------
// tcid_checker
// Port-level checks of the crack detector, bound to the top level.
// ----------------------------------------------------------------------------
module tcid_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic [tcid_pkg::ZONE_BITS-1:0]   out_zone,
    input logic [tcid_pkg::SAMPLE_BITS-1:0] average,
    input logic                             channel_active,
    input logic                             below_threshold,
    input logic [tcid_pkg::SAMPLE_BITS-1:0] zone_minimum,
    input logic [tcid_pkg::CH_BITS-1:0]     zone_minimum_channel,
    input logic                             zone_crack
);
    import tcid_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(average))
    else $error("stalled result changed");

    // below threshold only for an active channel, and it sets the crack flag
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && below_threshold |-> channel_active && zone_crack)
    else $error("below threshold without active channel or crack");

    // an active average never sits below the zone minimum
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && channel_active |-> zone_minimum <= average)
    else $error("zone minimum above active average");

    // an invalid zone reports the idle zone values
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (out_zone == ZONE_NONE) |->
            !channel_active && !zone_crack && (zone_minimum == SAMPLE_MAX)
            && (zone_minimum_channel == '0))
    else $error("invalid zone reported state");

endmodule

bind temp_compensated_ir_crack_detector tcid_checker u_tcid_checker (.*);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// temp_compensated_ir_crack_detector testbench
// Drives sensor beats at random rates under several zone mask settings,
// predicts every zone report from its own copy of the zone state and
// threshold tables, and checks each result beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcid_pkg::*;

    // code with no entry in the package
    localparam logic [INDEX_BITS-1:0] REG_NONE  = 2'd3;

    // threshold tables in tenths of a degree and raw counts
    localparam int MILD_ANCHOR [ZONES] = '{316, 314, 316};
    localparam int HOT_ANCHOR  [ZONES] = '{330, 330, 330};
    localparam int MILD_LEVEL [ZONES][CHANNELS] = '{
        '{370, 551, 565, 647, 0, 0, 0, 0},
        '{0, 0, 0, 376, 158, 175, 255, 221},
        '{370, 551, 565, 647, 0, 0, 0, 0}
    };
    localparam int HOT_LEVEL [ZONES][CHANNELS] = '{
        '{1480, 2204, 2260, 2588, 0, 0, 0, 0},
        '{0, 0, 0, 883, 632, 779, 1106, 1144},
        '{1480, 2204, 2260, 2588, 0, 0, 0, 0}
    };

    localparam int N_SETTINGS   = 7;
    localparam int PHASE_ITEMS  = 122;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_PCT     = 16;

    typedef struct {
        logic                        scan_start;
        logic [ZONE_BITS-1:0]        zone;
        logic [CH_BITS-1:0]          channel;
        logic [SAMPLE_BITS-1:0]      reading_a;
        logic [SAMPLE_BITS-1:0]      reading_b;
        logic [SAMPLE_BITS-1:0]      reading_c;
        logic signed [TEMP_BITS-1:0] temp_tenths;
    } sensor_item_t;

    typedef struct {
        logic [ZONE_BITS-1:0]   out_zone;
        logic [CH_BITS-1:0]     out_channel;
        logic [SAMPLE_BITS-1:0] average;
        logic                   channel_active;
        logic                   below_threshold;
        logic [SAMPLE_BITS-1:0] zone_minimum;
        logic [CH_BITS-1:0]     zone_minimum_channel;
        logic                   zone_crack;
    } zone_report_t;

    // zone tracking predictor and the queue of reports still owed
    class crack_report_board;
        logic [MASK_BITS-1:0]   mask    [ZONES];
        logic [SAMPLE_BITS-1:0] min_val [ZONES];
        logic [CH_BITS-1:0]     min_ch  [ZONES];
        logic                   crack   [ZONES];
        zone_report_t           owed_reports [$];
        int errors;
        int items_seen;
        int reports_seen;

        function new();
            mask[0] = LEFT_MASK_RST;
            mask[1] = CENTER_MASK_RST;
            mask[2] = RIGHT_MASK_RST;
            clear_zones();
            errors       = 0;
            items_seen   = 0;
            reports_seen = 0;
        endfunction

        function void clear_zones();
            for (int z = 0; z < ZONES; z++)
            begin
                min_val[z] = SAMPLE_MAX;
                min_ch[z]  = '0;
                crack[z]   = 1'b0;
            end
        endfunction

        function void set_mask(logic [INDEX_BITS-1:0] idx, logic [MASK_BITS-1:0] v);
            case (idx)
                REG_LEFT_MASK:   mask[0] = v;
                REG_CENTER_MASK: mask[1] = v;
                REG_RIGHT_MASK:  mask[2] = v;
                default:         ;
            endcase
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction

        // exact compare of average against the interpolated threshold
        function bit under_threshold(int z, int ch, int avg, int temp);
            int tm;
            int th;
            int span;
            int t;
            int lhs;
            int rhs;
            tm   = MILD_ANCHOR[z];
            th   = HOT_ANCHOR[z];
            span = th - tm;
            t    = temp;
            if (t < tm) t = tm;
            if (t > th) t = th;
            lhs = avg * span;
            rhs = MILD_LEVEL[z][ch] * span + (HOT_LEVEL[z][ch] - MILD_LEVEL[z][ch]) * (t - tm);
            return lhs < rhs;
        endfunction

        // accepted input beat: update zone state and queue the report
        function void note_item(sensor_item_t it);
            zone_report_t r;
            int zi;
            int ci;
            int sum;
            int avg;
            int temp;
            logic [MASK_BITS-1:0] m;
            items_seen++;
            zi   = it.zone;
            ci   = it.channel;
            sum  = it.reading_a + it.reading_b + it.reading_c;
            avg  = sum / 3;
            temp = it.temp_tenths;
            if (it.scan_start)
                clear_zones();
            r.out_zone             = it.zone;
            r.out_channel          = it.channel;
            r.average              = avg[SAMPLE_BITS-1:0];
            r.channel_active       = 1'b0;
            r.below_threshold      = 1'b0;
            r.zone_minimum         = SAMPLE_MAX;
            r.zone_minimum_channel = '0;
            r.zone_crack           = 1'b0;
            if (zi < ZONES)
            begin
                m = mask[zi];
                if (ci < CHANNELS && m[ci])
                begin
                    r.channel_active = 1'b1;
                    // equal to the stored minimum keeps the old channel
                    if (avg < min_val[zi])
                    begin
                        min_val[zi] = avg[SAMPLE_BITS-1:0];
                        min_ch[zi]  = it.channel;
                    end
                    if (under_threshold(zi, ci, avg, temp))
                    begin
                        r.below_threshold = 1'b1;
                        crack[zi] = 1'b1;
                    end
                end
                r.zone_minimum         = min_val[zi];
                r.zone_minimum_channel = min_ch[zi];
                r.zone_crack           = crack[zi];
            end
            owed_reports.push_back(r);
        endfunction

        function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // accepted result beat against the oldest owed report
        function void check_result(zone_report_t got);
            zone_report_t want;
            reports_seen++;
            if (owed_reports.size() == 0)
            begin
                $error("result beat with no report owed");
                errors++;
                return;
            end
            want = owed_reports.pop_front();
            cmp_field("out_zone", 16'(want.out_zone), 16'(got.out_zone));
            cmp_field("out_channel", 16'(want.out_channel), 16'(got.out_channel));
            cmp_field("average", 16'(want.average), 16'(got.average));
            cmp_field("channel_active", 16'(want.channel_active), 16'(got.channel_active));
            cmp_field("below_threshold", 16'(want.below_threshold),
                      16'(got.below_threshold));
            cmp_field("zone_minimum", 16'(want.zone_minimum), 16'(got.zone_minimum));
            cmp_field("zone_minimum_channel", 16'(want.zone_minimum_channel),
                      16'(got.zone_minimum_channel));
            cmp_field("zone_crack", 16'(want.zone_crack), 16'(got.zone_crack));
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n        = 1'b0;
    logic                        item_valid   = 1'b0;
    logic                        item_stall;
    logic                        scan_start   = 1'b0;
    logic [ZONE_BITS-1:0]        zone         = '0;
    logic [CH_BITS-1:0]          channel      = '0;
    logic [SAMPLE_BITS-1:0]      reading_a    = '0;
    logic [SAMPLE_BITS-1:0]      reading_b    = '0;
    logic [SAMPLE_BITS-1:0]      reading_c    = '0;
    logic signed [TEMP_BITS-1:0] temp_tenths  = '0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic [ZONE_BITS-1:0]        out_zone;
    logic [CH_BITS-1:0]          out_channel;
    logic [SAMPLE_BITS-1:0]      average;
    logic                        channel_active;
    logic                        below_threshold;
    logic [SAMPLE_BITS-1:0]      zone_minimum;
    logic [CH_BITS-1:0]          zone_minimum_channel;
    logic                        zone_crack;
    logic                        cfg_write    = 1'b0;
    logic [INDEX_BITS-1:0]       cfg_index    = '0;
    logic [MASK_BITS-1:0]        cfg_data     = '0;

    crack_report_board sb = new();
    int send_idle_pct  = IDLE_PCT;
    int recv_stall_pct = IDLE_PCT;
    bit hold_go        = 1'b0;

    temp_compensated_ir_crack_detector dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_valid           (item_valid),
        .item_stall           (item_stall),
        .scan_start           (scan_start),
        .zone                 (zone),
        .channel              (channel),
        .reading_a            (reading_a),
        .reading_b            (reading_b),
        .reading_c            (reading_c),
        .temp_tenths          (temp_tenths),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .out_zone             (out_zone),
        .out_channel          (out_channel),
        .average              (average),
        .channel_active       (channel_active),
        .below_threshold      (below_threshold),
        .zone_minimum         (zone_minimum),
        .zone_minimum_channel (zone_minimum_channel),
        .zone_crack           (zone_crack),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("temp_compensated_ir_crack_detector regression: fail");
        $finish;
    end

    // result side: check beats, random stalls and one long hold-off
    initial
    begin : result_side
        zone_report_t got;
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_stall === 1'b0)
            begin
                got.out_zone             = out_zone;
                got.out_channel          = out_channel;
                got.average              = average;
                got.channel_active       = channel_active;
                got.below_threshold      = below_threshold;
                got.zone_minimum         = zone_minimum;
                got.zone_minimum_channel = zone_minimum_channel;
                got.zone_crack           = zone_crack;
                sb.check_result(got);
            end
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_item(input sensor_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        scan_start  <= it.scan_start;
        zone        <= it.zone;
        channel     <= it.channel;
        reading_a   <= it.reading_a;
        reading_b   <= it.reading_b;
        reading_c   <= it.reading_c;
        temp_tenths <= it.temp_tenths;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        sb.note_item(it);
    endtask

    // register write; caller lowers cfg_write after the batch
    task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [MASK_BITS-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_mask(idx, v);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic sensor_item_t mk(int s, logic [ZONE_BITS-1:0] z, int c,
                                        int a, int b, int d, int t);
        sensor_item_t it;
        it.scan_start  = (s != 0);
        it.zone        = z;
        it.channel     = CH_BITS'(c);
        it.reading_a   = SAMPLE_BITS'(a);
        it.reading_b   = SAMPLE_BITS'(b);
        it.reading_c   = SAMPLE_BITS'(d);
        it.temp_tenths = TEMP_BITS'(t);
        return it;
    endfunction

    // readings cluster around a base, some fully random
    function automatic logic [SAMPLE_BITS-1:0] rand_reading(int base);
        int v;
        if ($urandom_range(0, 3) == 0)
            return SAMPLE_BITS'($urandom_range(0, 4095));
        v = base + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_BITS'(v);
    endfunction

    // mostly near the anchors, then the sensor range, then any code
    function automatic logic signed [TEMP_BITS-1:0] rand_temp();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return TEMP_BITS'($urandom_range(300, 345));
        else if (k < 8)
            return TEMP_BITS'(int'($urandom_range(0, 1650)) - 400);
        else
            return TEMP_BITS'($urandom_range(0, 4095));
    endfunction

    // scans: a scan start then a run of readings, with stray noise
    task automatic run_random(input int count, input int pause_at);
        sensor_item_t it;
        int sent;
        int run_len;
        int base;
        sent = 0;
        while (sent < count)
        begin
            run_len = $urandom_range(4, 24);
            for (int k = 0; k < run_len && sent < count; k++)
            begin
                base = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2700)
                                                  : $urandom_range(0, 4095);
                it.scan_start  = (k == 0) ? 1'b1 : ($urandom_range(0, 99) < 3);
                it.zone        = ($urandom_range(0, 99) < 8) ? ZONE_NONE
                                                             : ZONE_BITS'($urandom_range(0, 2));
                it.channel     = CH_BITS'($urandom_range(0, 7));
                it.reading_a   = rand_reading(base);
                it.reading_b   = rand_reading(base);
                it.reading_c   = rand_reading(base);
                it.temp_tenths = rand_temp();
                send_item(it);
                sent++;
                if (sent == pause_at)
                    drain();
            end
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [MASK_BITS-1:0] setting [N_SETTINGS][3];
        setting[0] = '{8'hFF, 8'hFF, 8'hFF};
        setting[1] = '{8'h00, 8'h00, 8'h00};
        setting[2] = '{8'h01, 8'h80, 8'hFE};
        setting[3] = '{MASK_BITS'($urandom_range(0, 255)), MASK_BITS'($urandom_range(0, 255)),
                       MASK_BITS'($urandom_range(0, 255))};
        setting[4] = '{8'hAA, 8'h55, 8'h0F};
        setting[5] = '{MASK_BITS'($urandom_range(0, 255)), MASK_BITS'($urandom_range(0, 255)),
                       MASK_BITS'($urandom_range(0, 255))};
        setting[6] = '{LEFT_MASK_RST, CENTER_MASK_RST, RIGHT_MASK_RST};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write to an unused index must leave the reset masks alone
        write_reg(REG_NONE, 8'hFF);
        cfg_write <= 1'b0;

        // directed beats under the reset masks
        send_item(mk(1, ZONE_LEFT, 0, 0, 0, 0, 316));
        send_item(mk(0, ZONE_LEFT, 1, 4095, 4095, 4095, 330));
        // average equal to the cleared minimum does not take it
        send_item(mk(1, ZONE_LEFT, 1, 4095, 4095, 4095, 2047));
        send_item(mk(0, ZONE_LEFT, 0, 1000, 1000, 1000, -2048));
        send_item(mk(0, ZONE_LEFT, 1, 1000, 1001, 999, 316));
        // threshold edges at both anchors
        send_item(mk(0, ZONE_LEFT, 0, 370, 370, 370, 316));
        send_item(mk(0, ZONE_LEFT, 0, 369, 369, 369, -400));
        send_item(mk(0, ZONE_LEFT, 0, 1479, 1479, 1479, 1250));
        send_item(mk(0, ZONE_LEFT, 0, 1480, 1480, 1480, 330));
        send_item(mk(0, ZONE_LEFT, 0, 4095, 4095, 4094, 323));
        send_item(mk(0, ZONE_LEFT, 5, 0, 0, 0, 320));
        send_item(mk(0, ZONE_LEFT, 3, 0, 0, 0, 1250));
        send_item(mk(0, ZONE_CENTER, 4, 100, 100, 100, 314));
        send_item(mk(0, ZONE_CENTER, 2, 0, 0, 0, 322));
        send_item(mk(0, ZONE_CENTER, 7, 682, 682, 682, 322));
        send_item(mk(0, ZONE_CENTER, 7, 683, 683, 683, 322));
        send_item(mk(0, ZONE_CENTER, 6, 4095, 4095, 4095, 2047));
        send_item(mk(0, ZONE_RIGHT, 1, 551, 551, 550, 316));
        send_item(mk(0, ZONE_RIGHT, 0, 2000, 2000, 2000, 325));
        // nonexistent zone, and a scan start arriving on it
        send_item(mk(0, ZONE_NONE, 0, 0, 0, 0, 0));
        send_item(mk(1, ZONE_NONE, 7, 4095, 4095, 4095, -1));
        send_item(mk(0, ZONE_LEFT, 0, 2000, 2000, 2000, -1));
        send_item(mk(0, ZONE_RIGHT, 7, 4095, 4095, 4095, -2048));
        drain();

        // random scans under each mask setting
        for (int p = 0; p < N_SETTINGS; p++)
        begin
            write_reg(REG_LEFT_MASK, setting[p][0]);
            write_reg(REG_CENTER_MASK, setting[p][1]);
            write_reg(REG_RIGHT_MASK, setting[p][2]);
            write_reg(REG_NONE, MASK_BITS'($urandom_range(0, 255)));
            cfg_write <= 1'b0;
            if (p == 0)
            begin
                // receiver holds off while the sender keeps offering beats
                send_idle_pct = 0;
                hold_go = 1'b1;
            end
            else if (p == 2)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else
            begin
                send_idle_pct  = IDLE_PCT;
                recv_stall_pct = IDLE_PCT;
            end
            run_random(PHASE_ITEMS, (p == 4) ? PHASE_ITEMS / 2 : -1);
            drain();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d item beats and %0d result beats over %0d mask settings",
                 sb.items_seen, sb.reports_seen, N_SETTINGS + 1);
        $display("including scan clears, the unused zone and register, and threshold edges");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("temp_compensated_ir_crack_detector regression: pass");
        else
            $display("temp_compensated_ir_crack_detector regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tcid_pkg.sv
rtl/temp_compensated_ir_crack_detector.sv
rtl/tcid_checker.sv
sim/testbench.sv
